[rtl/ffp_pkg.sv]
// ----------------------------------------------------------------------------
// ffp_pkg
// shared types and constants for the first-fit two-resource packer
// ----------------------------------------------------------------------------
package ffp_pkg;

	localparam int MAX_BINS  = 64;
	localparam int BIN_AW    = $clog2(MAX_BINS);
	localparam int CNT_W     = $clog2(MAX_BINS + 1);
	localparam int IDX_W     = 6;
	localparam int OPEN_W    = 7;
	localparam int CAP_W     = 16;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 16;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_PLACE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_LOADED    = 2'd0,
		ST_PLACED    = 2'd1,
		ST_TOO_LARGE = 2'd2,
		ST_NO_BIN    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} eng_state_t;

	typedef struct packed {
		logic [CAP_W-1:0] weight;
		logic [CAP_W-1:0] volume;
	} cap_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] bin_index;
		cap_t             cap;
	} item_t;

	typedef struct packed {
		status_t           status;
		logic [IDX_W-1:0]  chosen_bin;
		logic [OPEN_W-1:0] bins_opened;
	} result_t;

	typedef struct packed {
		logic              en;
		logic [BIN_AW-1:0] addr;
		cap_t              data;
	} mem_wr_t;

endpackage

[rtl/first_fit_two_resource_packer.sv]
// ----------------------------------------------------------------------------
// first_fit_two_resource_packer
// first-fit bin packing over weight and volume with a 64-entry capacity store
// ----------------------------------------------------------------------------
// results: a load goes straight to the result state; a package is first scanned
//   over the bins opened so far and the next one, and each result then passes the output register
// items: one item at a time, the next taken only after the result has left the
//   engine; the scan makes one store read per cycle
// reset: bin counts cleared; bin capacities undefined until loaded
module first_fit_two_resource_packer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [ffp_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // bin_index, weight, volume
	input  logic                            s_axis_tuser,  // operation
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [ffp_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // chosen_bin, bins_opened
	output logic [1:0]                      m_axis_tuser   // status
);
	import ffp_pkg::*;

	item_t             item;
	result_t           eng_res, out_q;
	logic              eng_res_valid, eng_res_ready;
	logic              out_vld_q;
	mem_wr_t           mem_wr;
	logic              mem_re;
	logic [BIN_AW-1:0] mem_raddr;
	cap_t              mem_rdata;

	assign item.op         = op_t'(s_axis_tuser);
	assign item.bin_index  = s_axis_tdata[IDX_W-1:0];
	assign item.cap.weight = s_axis_tdata[IDX_W +: CAP_W];
	assign item.cap.volume = s_axis_tdata[IDX_W+CAP_W +: CAP_W];

	ffp_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (item),
		.res_valid (eng_res_valid),
		.res_ready (eng_res_ready),
		.res       (eng_res),
		.mem_wr    (mem_wr),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	ffp_mem u_mem (
		.clk     (clk),
		.wr      (mem_wr),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	// output register
	assign eng_res_ready = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (eng_res_ready) begin
			out_vld_q <= eng_res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_res_valid && eng_res_ready) begin
			out_q <= eng_res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {(M_TDATA_W - IDX_W - OPEN_W)'(0), out_q.bins_opened,
	                        out_q.chosen_bin};

	// a placed package lands in an opened bin
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_PLACED |->
			OPEN_W'(m_axis_tdata[IDX_W-1:0]) < m_axis_tdata[IDX_W +: OPEN_W])
		else $error("placed bin not below opened count");

	// no bin left always reports bin zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_NO_BIN |-> m_axis_tdata[IDX_W-1:0] == '0)
		else $error("no-bin result with nonzero bin");

	// a rejected package names the next unopened bin
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_TOO_LARGE |->
			OPEN_W'(m_axis_tdata[IDX_W-1:0]) == m_axis_tdata[IDX_W +: OPEN_W])
		else $error("too-large result not at the next bin");

	// input is taken only with no result pending in the engine
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !eng_res_valid)
		else $error("input ready while a result is pending");

endmodule

[rtl/ffp_mem.sv]
// ----------------------------------------------------------------------------
// ffp_mem
// bin capacity store, one write and one registered read port
// ----------------------------------------------------------------------------
module ffp_mem (
	input  logic                     clk,
	input  ffp_pkg::mem_wr_t         wr,
	input  logic                     rd_en,
	input  logic [ffp_pkg::BIN_AW-1:0] rd_addr,
	output ffp_pkg::cap_t            rd_data
);
	import ffp_pkg::*;

	cap_t mem_q [MAX_BINS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[rtl/ffp_engine.sv]
// ----------------------------------------------------------------------------
// ffp_engine
// load and first-fit scan sequencer, read-modify-write on the capacity store
// ----------------------------------------------------------------------------
module ffp_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  ffp_pkg::item_t             in_item,
	output logic                       res_valid,
	input  logic                       res_ready,
	output ffp_pkg::result_t           res,
	output ffp_pkg::mem_wr_t           mem_wr,
	output logic                       mem_re,
	output logic [ffp_pkg::BIN_AW-1:0] mem_raddr,
	input  ffp_pkg::cap_t              mem_rdata
);
	import ffp_pkg::*;

	eng_state_t       state_q, state_d;
	logic [CNT_W-1:0] opened_q, loaded_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] chk_idx_s1;
	logic             chk_vld_s1;
	cap_t             pkg_q;
	result_t          res_q;

	logic             accept, is_load, load_ok;
	logic [CNT_W-1:0] load_idx;
	logic             fits, is_new, no_bin, hit, term;

	assign accept   = in_valid && in_ready;
	assign is_load  = (in_item.op == OP_LOAD);
	assign load_idx = CNT_W'(in_item.bin_index);
	assign load_ok  = (load_idx < CNT_W'(MAX_BINS));

	// compare stage on the registered read
	assign fits   = (mem_rdata.weight >= pkg_q.weight) && (mem_rdata.volume >= pkg_q.volume);
	assign is_new = (chk_idx_s1 == opened_q);
	assign no_bin = is_new && (opened_q >= loaded_q);
	assign hit    = chk_vld_s1 && !no_bin && fits;
	assign term   = chk_vld_s1 && (hit || is_new);

	assign mem_re    = (state_q == S_SCAN);
	assign mem_raddr = BIN_AW'(rd_idx_q);
	assign res       = res_q;

	always_comb begin
		mem_wr = '0;
		if (accept && is_load && load_ok) begin
			mem_wr.en   = 1'b1;
			mem_wr.addr = BIN_AW'(load_idx);
			mem_wr.data = in_item.cap;
		end else if (hit) begin
			mem_wr.en          = 1'b1;
			mem_wr.addr        = BIN_AW'(chk_idx_s1);
			mem_wr.data.weight = mem_rdata.weight - pkg_q.weight;
			mem_wr.data.volume = mem_rdata.volume - pkg_q.volume;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = is_load ? S_DONE : S_SCAN;
				end
			end
			S_SCAN: begin
				if (term) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// bin counts and scan pipeline valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opened_q   <= '0;
			loaded_q   <= '0;
			chk_vld_s1 <= 1'b0;
		end else begin
			chk_vld_s1 <= (state_q == S_SCAN) && !term && (rd_idx_q <= opened_q);
			if (accept && is_load && load_ok) begin
				if (load_idx == '0) begin
					opened_q <= '0;
					loaded_q <= CNT_W'(1);
				end else if (load_idx + CNT_W'(1) > loaded_q) begin
					loaded_q <= load_idx + CNT_W'(1);
				end
			end
			if (hit && is_new) begin
				opened_q <= chk_idx_s1 + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= rd_idx_q;
		if (accept) begin
			pkg_q    <= in_item.cap;
			rd_idx_q <= '0;
			if (is_load) begin
				res_q.status     <= ST_LOADED;
				res_q.chosen_bin <= in_item.bin_index;
				if (load_ok && load_idx == '0) begin
					res_q.bins_opened <= '0;
				end else begin
					res_q.bins_opened <= OPEN_W'(opened_q);
				end
			end
		end else if (state_q == S_SCAN) begin
			rd_idx_q <= rd_idx_q + CNT_W'(1);
		end
		if (term) begin
			priority if (hit) begin
				res_q.status      <= ST_PLACED;
				res_q.chosen_bin  <= IDX_W'(chk_idx_s1);
				res_q.bins_opened <= is_new ? OPEN_W'(chk_idx_s1 + CNT_W'(1))
				                            : OPEN_W'(opened_q);
			end else if (no_bin) begin
				res_q.status      <= ST_NO_BIN;
				res_q.chosen_bin  <= '0;
				res_q.bins_opened <= OPEN_W'(opened_q);
			end else begin
				res_q.status      <= ST_TOO_LARGE;
				res_q.chosen_bin  <= IDX_W'(chk_idx_s1);
				res_q.bins_opened <= OPEN_W'(opened_q);
			end
		end
	end

endmodule
